>>> rtl/ordered_list_table_engine_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_TABLE_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_UNIT_ASSERT_SVH

// Plain implication checked at every clock edge outside reset.
`define OLTE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define OLTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/olte_pkg.sv
package olte_pkg;
  localparam int unsigned FuncW  = 4;
  localparam int unsigned PosW   = 7;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DefCapacity = 64;

  localparam logic [FuncW-1:0] FnInsert    = 4'd0;
  localparam logic [FuncW-1:0] FnErase     = 4'd1;
  localparam logic [FuncW-1:0] FnFind      = 4'd2;
  localparam logic [FuncW-1:0] FnModify    = 4'd3;
  localparam logic [FuncW-1:0] FnClear     = 4'd4;
  localparam logic [FuncW-1:0] FnPushBack  = 4'd5;
  localparam logic [FuncW-1:0] FnPopBack   = 4'd6;
  localparam logic [FuncW-1:0] FnPushFront = 4'd7;
  localparam logic [FuncW-1:0] FnPopFront  = 4'd8;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StRange = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;

  // Operation as seen by the back end after classification.
  typedef enum logic [2:0] {
    OpNone, OpInsert, OpErase, OpFind, OpModify, OpClear
  } op_e;
endpackage

>>> rtl/olte_front.sv
// Decodes a request into a canonical operation and pushes it into a
// two-entry queue. Position checks need the count, so they happen in the back.
module olte_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [olte_pkg::FuncW-1:0]  func_i,
  input  logic [olte_pkg::PosW-1:0]   position_i,
  input  logic [olte_pkg::ValueW-1:0] value_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output olte_pkg::op_e               q_op_o,
  output logic [1:0]                  q_pmode_o,
  output logic [olte_pkg::PosW-1:0]   q_pos_o,
  output logic [olte_pkg::ValueW-1:0] q_value_o
);
  import olte_pkg::*;

  // pmode: 0 use position, 1 use zero, 2 use count, 3 use count minus one.
  logic [1:0]        vld_q;
  op_e               op_q    [2];
  logic [1:0]        pm_q    [2];
  logic [PosW-1:0]   pos_q   [2];
  logic [ValueW-1:0] val_q   [2];
  logic              wr_q, rd_q;
  op_e               dop;
  logic [1:0]        dpm;
  logic              push, pop;

  always_comb begin
    dop = OpNone;
    dpm = 2'd0;
    unique case (func_i)
      FnInsert:    dop = OpInsert;
      FnErase:     dop = OpErase;
      FnFind:      dop = OpFind;
      FnModify:    dop = OpModify;
      FnClear:     dop = OpClear;
      FnPushBack:  begin dop = OpInsert; dpm = 2'd2; end
      FnPopBack:   begin dop = OpErase;  dpm = 2'd3; end
      FnPushFront: begin dop = OpInsert; dpm = 2'd1; end
      FnPopFront:  begin dop = OpErase;  dpm = 2'd1; end
      default:     dop = OpNone;
    endcase
  end

  assign in_ready_o = ~vld_q[wr_q];
  assign push = in_valid_i & in_ready_o;
  assign q_valid_o = vld_q[rd_q];
  assign pop = q_valid_o & q_ready_i;
  assign q_op_o = op_q[rd_q];
  assign q_pmode_o = pm_q[rd_q];
  assign q_pos_o = pos_q[rd_q];
  assign q_value_o = val_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      if (push) begin
        vld_q[wr_q] <= 1'b1;
        wr_q <= ~wr_q;
      end
      if (pop) begin
        vld_q[rd_q] <= 1'b0;
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_q]  <= dop;
      pm_q[wr_q]  <= dpm;
      pos_q[wr_q] <= position_i;
      val_q[wr_q] <= value_i;
    end
  end
endmodule

>>> rtl/olte_back.sv
// Executes operations on a shifting chain of cells. Insert and erase shift
// the cells from the position upward at once; find uses a priority search over the cells.
module olte_back #(
  parameter int unsigned Capacity = olte_pkg::DefCapacity,
  parameter int unsigned CntW = $clog2(Capacity + 1),
  parameter int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  olte_pkg::op_e               q_op_i,
  input  logic [1:0]                  q_pmode_i,
  input  logic [olte_pkg::PosW-1:0]   q_pos_i,
  input  logic [olte_pkg::ValueW-1:0] q_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [olte_pkg::StatW-1:0]  status_o,
  output logic [CntW-1:0]             count_o,
  output logic                        found_o,
  output logic [IdxW-1:0]             found_index_o
);
  import olte_pkg::*;

  // Wide enough for the request position and for the count minus one.
  localparam int unsigned PW = ((CntW > PosW) ? CntW : PosW) + 1;

  logic [ValueW-1:0] cell_q [Capacity];
  logic [CntW-1:0]   cnt_q;
  logic              ov_q;
  logic [StatW-1:0]  st_q;
  logic              fnd_q;
  logic [IdxW-1:0]   fidx_q;

  logic              take;
  logic [PW-1:0]     pos;
  logic [StatW-1:0]  st;
  logic              do_ins, do_era, do_mod;
  logic [CntW-1:0]   cnt_d;
  logic              hit;
  logic [IdxW-1:0]   hidx;

  assign q_ready_o = ~ov_q | out_ready_i;
  assign take = q_valid_i & q_ready_o;

  always_comb begin
    unique case (q_pmode_i)
      2'd0:    pos = PW'(q_pos_i);
      2'd1:    pos = '0;
      2'd2:    pos = PW'(cnt_q);
      default: pos = PW'(cnt_q) - 1'b1;
    endcase
  end

  always_comb begin
    st = StOk;
    do_ins = 1'b0;
    do_era = 1'b0;
    do_mod = 1'b0;
    cnt_d = cnt_q;
    unique case (q_op_i)
      OpInsert: begin
        if (pos > PW'(cnt_q)) st = StRange;
        else if (cnt_q == CntW'(Capacity)) st = StFull;
        else begin do_ins = 1'b1; cnt_d = cnt_q + 1'b1; end
      end
      OpErase: begin
        if (cnt_q == '0 || pos >= PW'(cnt_q)) st = StRange;
        else begin do_era = 1'b1; cnt_d = cnt_q - 1'b1; end
      end
      OpModify: begin
        if (pos >= PW'(cnt_q)) st = StRange;
        else do_mod = 1'b1;
      end
      OpClear: cnt_d = '0;
      default: ;
    endcase
  end

  always_comb begin
    hit = 1'b0;
    hidx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (CntW'(i) < cnt_q && cell_q[i] == q_value_i) begin
        hit = 1'b1;
        hidx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < Capacity; i++) begin
        if (do_ins) begin
          if (PW'(i) == pos) cell_q[i] <= q_value_i;
          else if (PW'(i) > pos && i > 0) cell_q[i] <= cell_q[i-1];
        end else if (do_era) begin
          if (PW'(i) >= pos && i < Capacity - 1) cell_q[i] <= cell_q[i+1];
        end else if (do_mod) begin
          if (PW'(i) == pos) cell_q[i] <= q_value_i;
        end
      end
      st_q <= st;
      fnd_q <= (q_op_i == OpFind) & hit;
      fidx_q <= (q_op_i == OpFind) ? hidx : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q <= cnt_d;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign count_o = cnt_q;
  assign found_o = fnd_q;
  assign found_index_o = fidx_q;
endmodule

>>> rtl/ordered_list_table_engine_unit.sv
// A request is first registered in the front queue; the back then takes it
// from the queue, and the cell chain registers the result, which holds while
// the output is stalled. Throughput: one request per cycle sustained while
// the output is ready; the cell chain completes each operation in one
// register update, shifting the affected entries at once.
// Reset clears the entry count and all handshake state; entries stay undefined.
module ordered_list_table_engine_unit #(
  parameter int unsigned CAPACITY = olte_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: func [3:0], position [10:4], value [42:11], zero fill [47:43].
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status [1:0], count [8:2], found [9], found_index [15:10].
  output logic [15:0] m_axis_tdata
);
  import olte_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Each transaction is decoded by the front into a queued operation; the
  // back resolves positions against the live count and updates the cells.
  logic              qv, qr;
  op_e               qop;
  logic [1:0]        qpm;
  logic [PosW-1:0]   qpos;
  logic [ValueW-1:0] qval;
  logic [StatW-1:0]  st;
  logic [CntW-1:0]   cnt;
  logic              fnd;
  logic [IdxW-1:0]   fidx;

  olte_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tdata[3:0]), .position_i(s_axis_tdata[10:4]),
    .value_i(s_axis_tdata[42:11]),
    .q_valid_o(qv), .q_ready_i(qr), .q_op_o(qop), .q_pmode_o(qpm),
    .q_pos_o(qpos), .q_value_o(qval)
  );

  olte_back #(.Capacity(CAPACITY), .CntW(CntW), .IdxW(IdxW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_op_i(qop), .q_pmode_i(qpm),
    .q_pos_i(qpos), .q_value_i(qval),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(st), .count_o(cnt), .found_o(fnd), .found_index_o(fidx)
  );

  // The result fields are packed at the fixed widths of the result bus.
  assign m_axis_tdata = {6'(fidx), fnd, 7'(cnt), st};
endmodule

>>> rtl/olte_checker.sv
module olte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  `include "ordered_list_table_engine_unit_assert.svh"

  `OLTE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `OLTE_ASSERT_IMP(a_found_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[9], m_axis_tdata[15:10] == 6'd0, "index set without a hit")
  `OLTE_ASSERT_IMP(a_count_rng, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[8:2] <= 7'd64, "count beyond capacity")
  `OLTE_ASSERT_IMP(a_status_rng, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined status")
endmodule

bind ordered_list_table_engine_unit olte_checker u_olte_checker (.*);
